FILE: src/rbck_pkg.sv
// shared types, codes and constants of the rectangle blitter with color key
package rbck_pkg;

    localparam int COORD_BITS      = 12;
    localparam int DIM_W           = COORD_BITS + 1;
    localparam int SPAN_W          = COORD_BITS + 1;
    localparam int FLIP_W          = COORD_BITS + 2;
    localparam int PROD_W          = 2 * FLIP_W;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int OUT_ADDR_W      = 32;
    localparam int PIX_W           = 8;
    localparam int QDEPTH          = 2;
    localparam int COLOR_COUNT_DEF = 256;
    localparam int ADDR_BITS_DEF   = 32;

    // item kinds on the input channel
    localparam logic [1:0] KIND_TABLE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd5;

    typedef enum logic [1:0] {
        OP_TABLE = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_PIXEL = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]            kind;
        logic [PIX_W-1:0]      table_index;
        logic                  table_mark;
        logic [COORD_BITS-1:0] rect_left;
        logic [COORD_BITS-1:0] rect_right;
        logic [COORD_BITS-1:0] rect_top;
        logic [COORD_BITS-1:0] rect_bottom;
        logic [COORD_BITS-1:0] dest_col;
        logic [COORD_BITS-1:0] dest_row;
        logic                  keyed;
        logic [PIX_W-1:0]      pixel_in;
    } t_item;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] read_addr;
        logic [OUT_ADDR_W-1:0] write_addr;
        logic [PIX_W-1:0]      pixel_out;
        logic                  write_enable;
        logic                  last_pixel;
    } t_res;

    // decoded command handed from front to back
    typedef struct packed {
        t_op                   op;
        logic                  key;
        logic [PIX_W-1:0]      pix;
        logic                  mark;
        logic [SPAN_W-1:0]     span_w;
        logic [SPAN_W-1:0]     span_h;
        logic [PROD_W-1:0]     src_prod;
        logic [PROD_W-1:0]     dst_prod;
        logic [COORD_BITS-1:0] src_col;
        logic [COORD_BITS-1:0] dst_col;
    } t_cmd;

endpackage

FILE: src/rbck_front.sv
// front end: classifies items and computes flipped row offsets for a start
module rbck_front
    import rbck_pkg::*;
(
    input  logic             i_valid,
    input  logic             i_ready,
    input  t_item            i_item,
    input  logic [CFG_W-1:0] i_src_base,
    input  logic [DIM_W-1:0] i_src_width,
    input  logic [DIM_W-1:0] i_src_height,
    input  logic [CFG_W-1:0] i_dst_base,
    input  logic [DIM_W-1:0] i_dst_width,
    input  logic [DIM_W-1:0] i_dst_height,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic               drop;
    logic               empty;
    logic signed [FLIP_W-1:0] src_flip;
    logic signed [FLIP_W-1:0] dst_flip;
    logic signed [PROD_W-1:0] src_prod;
    logic signed [PROD_W-1:0] dst_prod;

    // memory row = height - 1 - top-down row, may go negative and wrap
    assign src_flip = $signed({1'b0, i_src_height}) - FLIP_W'(1)
                      - $signed({2'b00, i_item.rect_bottom});
    assign dst_flip = $signed({1'b0, i_dst_height}) - FLIP_W'(1)
                      - $signed({2'b00, i_item.dest_row});
    assign src_prod = src_flip * $signed({1'b0, i_src_width});
    assign dst_prod = dst_flip * $signed({1'b0, i_dst_width});

    assign empty = (i_item.rect_right < i_item.rect_left)
                || (i_item.rect_bottom < i_item.rect_top)
                || (i_src_base == '0) || (i_dst_base == '0);

    always_comb begin
        drop           = 1'b0;
        o_cmd          = '0;
        o_cmd.key      = i_item.keyed;
        o_cmd.pix      = (i_item.kind == KIND_TABLE) ? i_item.table_index : i_item.pixel_in;
        o_cmd.mark     = i_item.table_mark;
        o_cmd.span_w   = {1'b0, i_item.rect_right} - {1'b0, i_item.rect_left} + SPAN_W'(1);
        o_cmd.span_h   = {1'b0, i_item.rect_bottom} - {1'b0, i_item.rect_top} + SPAN_W'(1);
        o_cmd.src_prod = src_prod;
        o_cmd.dst_prod = dst_prod;
        o_cmd.src_col  = i_item.rect_left;
        o_cmd.dst_col  = i_item.dest_col;
        unique case (i_item.kind)
            KIND_TABLE: begin
                o_cmd.op = OP_TABLE;
            end
            KIND_START: begin
                o_cmd.op = empty ? OP_STOP : OP_START;
            end
            KIND_PIXEL: begin
                o_cmd.op = OP_PIXEL;
            end
            default: begin
                o_cmd.op = OP_STOP;
                drop     = 1'b1;
            end
        endcase
    end

    assign o_push = i_valid && i_ready && !drop;

endmodule

FILE: src/rbck_queue.sv
// short command queue between front and back
module rbck_queue
    import rbck_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_cnt != CNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = r_rp + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QDEPTH))
        else $error("queue count above depth");

endmodule

FILE: src/rbck_back.sv
// back end: blit counters, row addresses, transparency marks, output register
module rbck_back
    import rbck_pkg::*;
#(
    parameter int COLOR_COUNT = COLOR_COUNT_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    input  logic [CFG_W-1:0] i_src_base,
    input  logic [DIM_W-1:0] i_src_width,
    input  logic [CFG_W-1:0] i_dst_base,
    input  logic [DIM_W-1:0] i_dst_width,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_res             o_out_data
);

    localparam int CIDX_W = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
    localparam logic [PIX_W:0] COLOR_LIM = (PIX_W + 1)'(COLOR_COUNT);

    logic                   r_marks [COLOR_COUNT];
    logic                   r_clearing;
    logic [CIDX_W-1:0]      r_clr_idx;
    logic                   r_mark_rd;
    logic                   r_active, n_active;
    logic                   r_key, n_key;
    logic [COORD_BITS-1:0]  r_col, n_col;
    logic [SPAN_W-1:0]      r_row, n_row;
    logic [SPAN_W-1:0]      r_span_w, n_span_w;
    logic [SPAN_W-1:0]      r_span_h, n_span_h;
    logic [ADDR_BITS-1:0]   r_src_row, n_src_row;
    logic [ADDR_BITS-1:0]   r_dst_row, n_dst_row;
    logic                   r_out_vld, n_out_vld;
    t_res                   r_out, n_out;

    logic [ADDR_BITS+CFG_W-1:0]  src_base_x;
    logic [ADDR_BITS+CFG_W-1:0]  dst_base_x;
    logic [ADDR_BITS+PROD_W-1:0] src_prod_x;
    logic [ADDR_BITS+PROD_W-1:0] dst_prod_x;
    logic [ADDR_BITS-1:0]        src_start;
    logic [ADDR_BITS-1:0]        dst_start;
    logic [ADDR_BITS-1:0]        col_a;
    logic [ADDR_BITS-1:0]        src_pix;
    logic [ADDR_BITS-1:0]        dst_pix;
    logic [ADDR_BITS+OUT_ADDR_W-1:0] src_pix_x;
    logic [ADDR_BITS+OUT_ADDR_W-1:0] dst_pix_x;
    logic [SPAN_W-1:0]           col_inc;
    logic [SPAN_W-1:0]           row_inc;
    logic                        in_range;
    logic                        take_beat;
    logic [CIDX_W-1:0]           cidx;

    // bases and signed products brought to the address width, wrapping
    assign src_base_x = {{ADDR_BITS{1'b0}}, i_src_base};
    assign dst_base_x = {{ADDR_BITS{1'b0}}, i_dst_base};
    assign src_prod_x = {{ADDR_BITS{i_cmd.src_prod[PROD_W-1]}}, i_cmd.src_prod};
    assign dst_prod_x = {{ADDR_BITS{i_cmd.dst_prod[PROD_W-1]}}, i_cmd.dst_prod};

    assign src_start = src_base_x[ADDR_BITS-1:0] + src_prod_x[ADDR_BITS-1:0]
                     + {{(ADDR_BITS-COORD_BITS){1'b0}}, i_cmd.src_col};
    assign dst_start = dst_base_x[ADDR_BITS-1:0] + dst_prod_x[ADDR_BITS-1:0]
                     + {{(ADDR_BITS-COORD_BITS){1'b0}}, i_cmd.dst_col};

    assign col_a     = {{(ADDR_BITS-COORD_BITS){1'b0}}, r_col};
    assign src_pix   = r_src_row + col_a;
    assign dst_pix   = r_dst_row + col_a;
    assign src_pix_x = {{OUT_ADDR_W{1'b0}}, src_pix};
    assign dst_pix_x = {{OUT_ADDR_W{1'b0}}, dst_pix};

    assign col_inc  = {1'b0, r_col} + SPAN_W'(1);
    assign row_inc  = r_row + SPAN_W'(1);
    assign in_range = ({1'b0, i_cmd.pix} < COLOR_LIM);
    assign cidx     = i_cmd.pix[CIDX_W-1:0];

    // take a command whenever the output register is free or draining and the marks are not being cleared
    assign o_pop = i_valid && !r_clearing && (!r_out_vld || i_out_ready);
    assign take_beat = o_pop && (i_cmd.op == OP_PIXEL) && r_active;

    always_comb begin
        n_active  = r_active;
        n_key     = r_key;
        n_col     = r_col;
        n_row     = r_row;
        n_span_w  = r_span_w;
        n_span_h  = r_span_h;
        n_src_row = r_src_row;
        n_dst_row = r_dst_row;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_TABLE: begin
                    n_active = r_active;
                end
                OP_START: begin
                    n_active  = 1'b1;
                    n_key     = i_cmd.key;
                    n_col     = '0;
                    n_row     = '0;
                    n_span_w  = i_cmd.span_w;
                    n_span_h  = i_cmd.span_h;
                    n_src_row = src_start;
                    n_dst_row = dst_start;
                end
                OP_STOP: begin
                    n_active = 1'b0;
                end
                OP_PIXEL: begin
                    if (r_active) begin
                        n_out_vld          = 1'b1;
                        n_out.read_addr    = src_pix_x[OUT_ADDR_W-1:0];
                        n_out.write_addr   = dst_pix_x[OUT_ADDR_W-1:0];
                        n_out.pixel_out    = i_cmd.pix;
                        // write forced on unless keyed with an in-range color, the mark decides at the output
                        n_out.write_enable = !(r_key && in_range);
                        n_out.last_pixel   = 1'b0;
                        n_col              = col_inc[COORD_BITS-1:0];
                        if (col_inc >= r_span_w) begin
                            // row done: step both row addresses upward
                            n_col     = '0;
                            n_row     = row_inc;
                            n_src_row = r_src_row
                                      + {{(ADDR_BITS-DIM_W){1'b0}}, i_src_width};
                            n_dst_row = r_dst_row
                                      + {{(ADDR_BITS-DIM_W){1'b0}}, i_dst_width};
                            if (row_inc >= r_span_h) begin
                                n_active         = 1'b0;
                                n_out.last_pixel = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_key     <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_span_w  <= '0;
            r_span_h  <= '0;
            r_src_row <= '0;
            r_dst_row <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_key     <= n_key;
            r_col     <= n_col;
            r_row     <= n_row;
            r_span_w  <= n_span_w;
            r_span_h  <= n_span_h;
            r_src_row <= n_src_row;
            r_dst_row <= n_dst_row;
            r_out_vld <= n_out_vld;
        end
    end

    // one mark cleared per cycle after reset, commands wait until done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + CIDX_W'(1);
            if (r_clr_idx == CIDX_W'(COLOR_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_marks[r_clr_idx] <= 1'b0;
        end else if (o_pop && (i_cmd.op == OP_TABLE) && in_range) begin
            r_marks[cidx] <= i_cmd.mark;
        end
    end

    // mark read at the pop edge of the pixel, lands with its beat
    always_ff @(posedge i_clk) begin
        if (take_beat) begin
            r_mark_rd <= r_marks[cidx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;

    always_comb begin
        o_out_data              = r_out;
        o_out_data.write_enable = r_out.write_enable || !r_mark_rd;
    end

    a_pixel_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.op == OP_PIXEL) && r_active) |=> r_out_vld)
        else $error("pixel of an active blit gave no beat");

    a_last_ends_blit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.last_pixel) |-> !r_active)
        else $error("blit still active after last pixel");

    a_col_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> ({1'b0, r_col} < r_span_w) && (r_row < r_span_h))
        else $error("counters outside the span");

    a_stall_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !o_pop)
        else $error("command taken while output stalled");

endmodule

FILE: src/rect_blit_color_key.sv
// top level of the rectangle blitter address generator with color key filter
//
//  port group  direction  handshake               payload
//  in          input      i_in_valid/o_in_ready    t_item: table write, start, pixel
//  out         output     o_out_valid/i_out_ready  t_res: addresses, pixel, flags
//  cfg         input      i_cfg_we                 i_cfg_idx, i_cfg_data
//
//  one item per cycle sustained while out is ready and the marks are not being cleared;
//  a pixel item is registered in the queue, then in the back end's output register
//  the start offsets use one 14x14 multiplier per buffer in the front stage
//  synchronous active-low reset clears control state, then the transparency marks
//  are cleared one per cycle until all are clear; input stalls once the queue fills
//  the two-entry queue lets the input keep flowing while out stalls, until it fills
module rect_blit_color_key
    import rbck_pkg::*;
#(
    parameter int COLOR_COUNT = COLOR_COUNT_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_item                i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_res                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_src_base;
    logic [DIM_W-1:0] r_src_width;
    logic [DIM_W-1:0] r_src_height;
    logic [CFG_W-1:0] r_dst_base;
    logic [DIM_W-1:0] r_dst_width;
    logic [DIM_W-1:0] r_dst_height;

    logic q_ready;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base   <= '0;
            r_src_width  <= DIM_W'(1);
            r_src_height <= DIM_W'(1);
            r_dst_base   <= '0;
            r_dst_width  <= DIM_W'(1);
            r_dst_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_BASE:   r_src_base   <= i_cfg_data;
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[DIM_W-1:0];
                REG_DST_BASE:   r_dst_base   <= i_cfg_data;
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DIM_W-1:0];
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                    r_src_base <= r_src_base;
                end
            endcase
        end
    end

    assign o_in_ready = q_ready;

    rbck_front u_front (
        .i_valid      (i_in_valid),
        .i_ready      (q_ready),
        .i_item       (i_in_data),
        .i_src_base   (r_src_base),
        .i_src_width  (r_src_width),
        .i_src_height (r_src_height),
        .i_dst_base   (r_dst_base),
        .i_dst_width  (r_dst_width),
        .i_dst_height (r_dst_height),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rbck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rbck_back #(
        .COLOR_COUNT (COLOR_COUNT),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .i_src_base  (r_src_base),
        .i_src_width (r_src_width),
        .i_dst_base  (r_dst_base),
        .i_dst_width (r_dst_width),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: dv/rbck_checker.sv
// watches the item, result and register ports of the blitter, predicts every result beat and compares
`timescale 1ns / 100ps

module rbck_checker
    import rbck_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_item                i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_res                 i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // register copies
    logic [OUT_ADDR_W-1:0] src_base, dst_base;
    logic [DIM_W-1:0]      src_w, src_h, dst_w, dst_h;

    // blit state
    logic                  clear_mark [256];
    logic                  active, key_en;
    logic [SPAN_W-1:0]     col_cnt, row_cnt, span_w, span_h;
    logic [OUT_ADDR_W-1:0] src_row, dst_row;

    t_res expected_beats [$];
    int   fail_total   = 0;
    int   pending_beats = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_beats;

    task automatic report(input string what);
        fail_total++;
        if (fail_total <= 50) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic clear_model();
        src_base = '0;
        dst_base = '0;
        src_w    = 1;
        src_h    = 1;
        dst_w    = 1;
        dst_h    = 1;
        for (int k = 0; k < 256; k++) clear_mark[k] = 1'b0;
        active  = 1'b0;
        key_en  = 1'b0;
        col_cnt = '0;
        row_cnt = '0;
        span_w  = '0;
        span_h  = '0;
        src_row = '0;
        dst_row = '0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_SRC_BASE:   src_base = data;
            REG_SRC_WIDTH:  src_w    = data[DIM_W-1:0];
            REG_SRC_HEIGHT: src_h    = data[DIM_W-1:0];
            REG_DST_BASE:   dst_base = data;
            REG_DST_WIDTH:  dst_w    = data[DIM_W-1:0];
            REG_DST_HEIGHT: dst_h    = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    // bottom-up buffers: top-down row r sits at memory row h-1-r, wrapping freely
    function automatic logic [OUT_ADDR_W-1:0] row_start(input logic [OUT_ADDR_W-1:0] base,
                                                        input logic [DIM_W-1:0] w,
                                                        input logic [DIM_W-1:0] h,
                                                        input logic [COORD_BITS-1:0] row,
                                                        input logic [COORD_BITS-1:0] col);
        logic [OUT_ADDR_W-1:0] flipped;
        flipped = 32'(h) - 32'd1 - 32'(row);
        return base + flipped * 32'(w) + 32'(col);
    endfunction

    task automatic open_blit(input t_item it);
        active = 1'b0;
        if (it.rect_right < it.rect_left || it.rect_bottom < it.rect_top
            || src_base == '0 || dst_base == '0) begin
            return;
        end
        span_w  = 13'(it.rect_right) - 13'(it.rect_left) + 13'd1;
        span_h  = 13'(it.rect_bottom) - 13'(it.rect_top) + 13'd1;
        col_cnt = '0;
        row_cnt = '0;
        key_en  = it.keyed;
        src_row = row_start(src_base, src_w, src_h, it.rect_bottom, it.rect_left);
        dst_row = row_start(dst_base, dst_w, dst_h, it.dest_row, it.dest_col);
        active  = 1'b1;
    endtask

    task automatic blit_step(input t_item it);
        t_res beat;
        case (it.kind)
            KIND_TABLE: clear_mark[it.table_index] = it.table_mark;
            KIND_START: open_blit(it);
            KIND_PIXEL: begin
                if (active) begin
                    beat.read_addr    = src_row + 32'(col_cnt);
                    beat.write_addr   = dst_row + 32'(col_cnt);
                    beat.pixel_out    = it.pixel_in;
                    beat.write_enable = !(key_en && clear_mark[it.pixel_in]);
                    beat.last_pixel   = 1'b0;
                    col_cnt++;
                    if (col_cnt >= span_w) begin
                        col_cnt = '0;
                        row_cnt++;
                        // row step uses the registers as they are now
                        src_row = src_row + 32'(src_w);
                        dst_row = dst_row + 32'(dst_w);
                        if (row_cnt >= span_h) begin
                            beat.last_pixel = 1'b1;
                            active = 1'b0;
                        end
                    end
                    expected_beats.push_back(beat);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_beat(input t_res got);
        t_res want;
        if (expected_beats.size() == 0) begin
            report($sformatf("result beat with nothing expected: %h", got));
            return;
        end
        want = expected_beats.pop_front();
        if (got.read_addr !== want.read_addr)
            report($sformatf("read_addr %h expected %h", got.read_addr, want.read_addr));
        if (got.write_addr !== want.write_addr)
            report($sformatf("write_addr %h expected %h", got.write_addr, want.write_addr));
        if (got.pixel_out !== want.pixel_out)
            report($sformatf("pixel_out %h expected %h", got.pixel_out, want.pixel_out));
        if (got.write_enable !== want.write_enable)
            report($sformatf("write_enable %b expected %b", got.write_enable,
                             want.write_enable));
        if (got.last_pixel !== want.last_pixel)
            report($sformatf("last_pixel %b expected %b", got.last_pixel, want.last_pixel));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            expected_beats.delete();
        end else begin
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_data);
            // compare first so a beat can never match an item taken at this edge
            if (i_out_valid && i_out_ready) check_beat(i_out_data);
            if (i_in_valid && i_in_ready) blit_step(i_in_data);
        end
        pending_beats = expected_beats.size();
    end

endmodule

FILE: dv/tb_rect_blit_color_key.sv
// testbench top of the rectangle blitter: clock, reset, register setup, item and ready stimulus
`timescale 1ns / 100ps

module tb_rect_blit_color_key;
    import rbck_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_item                in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = REG_SRC_BASE;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic  o_in_ready;
    logic  o_out_valid;
    t_res  o_out_data;
    int    fail_count;
    int    pending_beats;

    int    items_sent     = 0;
    int    out_beats      = 0;
    bit    steady         = 1'b0;
    bit    long_hold_done = 1'b0;

    rect_blit_color_key dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    rbck_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && out_ready) out_beats <= out_beats + 1;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // mostly short idles, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h5A;
            3: return 8'hA5;
            default: return 8'($urandom());
        endcase
    endfunction

    // unused fields carry random junk that the block has to ignore
    function automatic t_item junk_item(input logic [1:0] kind);
        logic  [95:0] bits;
        t_item it;
        bits    = {$urandom(), $urandom(), $urandom()};
        it      = bits[$bits(t_item)-1:0];
        it.kind = kind;
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.kind != KIND_NONE) items_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_table(input logic [PIX_W-1:0] idx, input logic mark);
        t_item it;
        it             = junk_item(KIND_TABLE);
        it.table_index = idx;
        it.table_mark  = mark;
        send_item(it);
    endtask

    task automatic send_start(input logic [COORD_BITS-1:0] l, r, t, b, dc, dr,
                              input logic key);
        t_item it;
        it             = junk_item(KIND_START);
        it.rect_left   = l;
        it.rect_right  = r;
        it.rect_top    = t;
        it.rect_bottom = b;
        it.dest_col    = dc;
        it.dest_row    = dr;
        it.keyed       = key;
        send_item(it);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        t_item it;
        it          = junk_item(KIND_PIXEL);
        it.pixel_in = pix;
        send_item(it);
    endtask

    task automatic send_noise();
        send_item(junk_item(KIND_NONE));
    endtask

    task automatic program_buffers(input logic [31:0] sb, input int sw, input int sh,
                                   input logic [31:0] db, input int dw, input int dh);
        logic [CFG_IDX_W-1:0] order [6];
        logic [CFG_W-1:0]     vals  [6];
        order = '{REG_SRC_BASE, REG_SRC_WIDTH, REG_SRC_HEIGHT,
                  REG_DST_BASE, REG_DST_WIDTH, REG_DST_HEIGHT};
        vals  = '{sb, 32'(sw), 32'(sh), db, 32'(dw), 32'(dh)};
        for (int k = 0; k < 6; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= order[k];
            cfg_data <= vals[k];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // wait until every expected beat is out, then let table or start items settle
    task automatic drain_block();
        if (in_valid) in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_beats != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_blit();
        int w, h, n, left, top;
        logic [COORD_BITS-1:0] l, r, t, b;
        w    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        h    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
        left = $urandom_range(0, 4096 - w);
        top  = $urandom_range(0, 4096 - h);
        l    = COORD_BITS'(left);
        r    = COORD_BITS'(left + w - 1);
        t    = COORD_BITS'(top);
        b    = COORD_BITS'(top + h - 1);
        n    = w * h;
        case ($urandom_range(0, 15))
            0: begin
                l = COORD_BITS'($urandom_range(1, 4095));
                r = COORD_BITS'($urandom_range(0, l - 1));
                n = 0;
            end
            1: begin
                t = COORD_BITS'($urandom_range(1, 4095));
                b = COORD_BITS'($urandom_range(0, t - 1));
                n = 0;
            end
            // cut short, the next start replaces it
            2: n = $urandom_range(0, n - 1);
            default: ;
        endcase
        send_start(l, r, t, b, 12'($urandom()), 12'($urandom()), 1'($urandom()));
        if (n == 0) send_pixel(pick_color());
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0) send_table(pick_color(), 1'($urandom()));
            send_pixel(pick_color());
        end
    endtask

    task automatic random_sequence();
        int pick;
        steady = ($urandom_range(0, 4) == 0);
        pick   = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 4)) send_table(pick_color(), 1'($urandom()));
        end else if (pick < 88) begin
            random_blit();
        end else if (pick < 94) begin
            send_noise();
        end else begin
            send_pixel(pick_color());
        end
    endtask

    // result side: random ready pattern plus one long hold-off mid-run
    initial begin
        int run, gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && out_beats >= 150) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: both bases absent, nothing may come out
        send_start(12'd0, 12'd1, 12'd0, 12'd1, 12'd0, 12'd0, 1'b1);
        send_pixel(8'h11);
        send_noise();
        drain_block();

        program_buffers(32'h0000_1000, 64, 32, 32'h0010_0000, 100, 50);
        send_table(8'h00, 1'b1);
        send_table(8'hFF, 1'b1);
        send_table(8'h07, 1'b1);
        send_start(12'd2, 12'd4, 12'd1, 12'd2, 12'd3, 12'd5, 1'b1);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h07);
        send_pixel(8'h08);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        // empty in columns, then in rows
        send_start(12'd5, 12'd4, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_pixel(8'h01);
        send_start(12'd0, 12'd0, 12'd3, 12'd2, 12'd0, 12'd0, 1'b0);
        // unkeyed copy of a marked color still writes
        send_start(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_pixel(8'h00);
        // restart mid-blit onto the far corner
        send_start(12'd0, 12'd1, 12'd0, 12'd1, 12'd10, 12'd10, 1'b1);
        send_pixel(8'h03);
        send_start(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
        send_pixel(8'hFF);
        // mark changes land on the next pixel
        send_start(12'd10, 12'd12, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        send_pixel(8'h09);
        send_table(8'h09, 1'b1);
        send_pixel(8'h09);
        send_table(8'h09, 1'b0);
        send_pixel(8'h09);
        drain_block();

        // destination absent
        program_buffers(32'h0000_1000, 64, 32, 32'h0000_0000, 100, 50);
        send_start(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_pixel(8'h01);
        drain_block();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: program_buffers(32'hFFFF_FFFF, 4096, 4096, 32'hFFFF_FFFF, 4096, 4096);
                1: program_buffers(32'h0000_0001, 1, 1, 32'h0000_0001, 1, 1);
                default: program_buffers($urandom() | 32'h1, $urandom_range(1, 4096),
                                         $urandom_range(1, 4096), $urandom() | 32'h1,
                                         $urandom_range(1, 4096), $urandom_range(1, 4096));
            endcase
            target = items_sent + 260;
            while (items_sent < target) random_sequence();
            drain_block();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/rbck_pkg.sv
src/rbck_front.sv
src/rbck_queue.sv
src/rbck_back.sv
src/rect_blit_color_key.sv
dv/rbck_checker.sv
dv/tb_rect_blit_color_key.sv
